@@ rtl/core/mfp_pkg.sv @@
// Shared types, codes and constants of the message frame parser.
`default_nettype none

package mfp_pkg;

    // Width of length counters and of the wide configuration registers.
    localparam int LEN_BITS = 24;
    // Width of an assembled big-endian field.
    localparam int WORD_BITS = 32;
    // Width of header counts, indexes and byte-wide registers.
    localparam int BYTE_BITS = 8;
    // Bytes in every length or count field.
    localparam int FIELD_BYTES = 4;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_PAYLOAD      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_TYPE         = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HEADER_LIMIT     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TABLE_SIZE       = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_HEADER_BYTES = 3'd4;

    // Commands.
    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    // Byte classes.
    localparam logic [3:0] CLS_IGNORED   = 4'd0;
    localparam logic [3:0] CLS_LENGTH    = 4'd1;
    localparam logic [3:0] CLS_TYPE      = 4'd2;
    localparam logic [3:0] CLS_COUNT     = 4'd3;
    localparam logic [3:0] CLS_NAME_LEN  = 4'd4;
    localparam logic [3:0] CLS_NAME      = 4'd5;
    localparam logic [3:0] CLS_VALUE_LEN = 4'd6;
    localparam logic [3:0] CLS_VALUE     = 4'd7;
    localparam logic [3:0] CLS_BODY      = 4'd8;

    // Status codes.
    localparam logic [2:0] ST_BUSY          = 3'd0;
    localparam logic [2:0] ST_OK            = 3'd1;
    localparam logic [2:0] ST_INVALID       = 3'd2;
    localparam logic [2:0] ST_TOO_LARGE     = 3'd3;
    localparam logic [2:0] ST_TOO_MANY_HDRS = 3'd4;
    localparam logic [2:0] ST_BAD_HEADER    = 3'd5;
    localparam logic [2:0] ST_HEADER_LARGE  = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [LEN_BITS-1:0]  RST_MAX_PAYLOAD      = 24'd65536;
    localparam logic [BYTE_BITS-1:0] RST_MAX_TYPE         = 8'd7;
    localparam logic [BYTE_BITS-1:0] RST_HEADER_LIMIT     = 8'd64;
    localparam logic [BYTE_BITS-1:0] RST_TABLE_SIZE       = 8'd64;
    localparam logic [LEN_BITS-1:0]  RST_MAX_HEADER_BYTES = 24'd8192;

    typedef struct packed {
        logic                 command;
        logic [LEN_BITS-1:0]  buffer_len;
        logic [BYTE_BITS-1:0] data_byte;
    } mfp_in_t;

    typedef struct packed {
        logic [BYTE_BITS-1:0] data_byte_out;
        logic [3:0]           byte_class;
        logic [BYTE_BITS-1:0] header_index;
        logic [WORD_BITS-1:0] field_value;
        logic                 field_complete;
        logic [2:0]           status;
        logic                 frame_done;
    } mfp_out_t;

    typedef struct packed {
        logic [LEN_BITS-1:0]  max_payload;
        logic [BYTE_BITS-1:0] max_type;
        logic [BYTE_BITS-1:0] header_limit;
        logic [BYTE_BITS-1:0] table_size;
        logic [LEN_BITS-1:0]  max_header_bytes;
    } mfp_cfg_t;

endpackage

`default_nettype wire

@@ rtl/core/mfp_cfg_regs.sv @@
// Configuration register file of the message frame parser.
`default_nettype none

module mfp_cfg_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [mfp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [mfp_pkg::LEN_BITS-1:0]       cfg_wdata,
    output mfp_pkg::mfp_cfg_t                       cfg
);

    mfp_pkg::mfp_cfg_t cfg_reg;
    mfp_pkg::mfp_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                mfp_pkg::REG_MAX_PAYLOAD:
                    cfg_next.max_payload = cfg_wdata;
                mfp_pkg::REG_MAX_TYPE:
                    cfg_next.max_type = cfg_wdata[mfp_pkg::BYTE_BITS-1:0];
                mfp_pkg::REG_HEADER_LIMIT:
                    cfg_next.header_limit = cfg_wdata[mfp_pkg::BYTE_BITS-1:0];
                mfp_pkg::REG_TABLE_SIZE:
                    cfg_next.table_size = cfg_wdata[mfp_pkg::BYTE_BITS-1:0];
                mfp_pkg::REG_MAX_HEADER_BYTES:
                    cfg_next.max_header_bytes = cfg_wdata;
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_payload      <= mfp_pkg::RST_MAX_PAYLOAD;
            cfg_reg.max_type         <= mfp_pkg::RST_MAX_TYPE;
            cfg_reg.header_limit     <= mfp_pkg::RST_HEADER_LIMIT;
            cfg_reg.table_size       <= mfp_pkg::RST_TABLE_SIZE;
            cfg_reg.max_header_bytes <= mfp_pkg::RST_MAX_HEADER_BYTES;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ rtl/core/mfp_parser.sv @@
// Frame parsing state and the per-byte decision logic.
`default_nettype none

module mfp_parser (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire mfp_pkg::mfp_in_t  item,
    input  wire mfp_pkg::mfp_cfg_t cfg,
    output mfp_pkg::mfp_out_t      result
);

    localparam int LB = mfp_pkg::LEN_BITS;
    localparam int WB = mfp_pkg::WORD_BITS;
    localparam int BB = mfp_pkg::BYTE_BITS;

    // Parsing phases share their codes with the byte classes they produce.
    typedef enum logic [3:0] {
        PH_IDLE  = mfp_pkg::CLS_IGNORED,
        PH_LEN   = mfp_pkg::CLS_LENGTH,
        PH_TYPE  = mfp_pkg::CLS_TYPE,
        PH_COUNT = mfp_pkg::CLS_COUNT,
        PH_NLEN  = mfp_pkg::CLS_NAME_LEN,
        PH_NAME  = mfp_pkg::CLS_NAME,
        PH_VLEN  = mfp_pkg::CLS_VALUE_LEN,
        PH_VALUE = mfp_pkg::CLS_VALUE,
        PH_BODY  = mfp_pkg::CLS_BODY
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [1:0]      bif_reg, bif_next;
    logic [WB-1:0]   acc_reg, acc_next;
    logic [LB-1:0]   payload_left_reg, payload_left_next;
    logic [LB-1:0]   source_len_reg, source_len_next;
    logic [BB-1:0]   headers_left_reg, headers_left_next;
    logic [BB-1:0]   cur_hdr_reg, cur_hdr_next;
    logic [LB-1:0]   name_size_reg, name_size_next;
    logic [LB-1:0]   data_left_reg, data_left_next;
    logic [2:0]      final_status_reg, final_status_next;

    logic [BB-1:0]   b;
    logic [LB-1:0]   pl_dec;
    logic [LB-1:0]   dl_dec;
    logic [BB-1:0]   hl_dec;
    logic [LB-1:0]   src_minus_hdr;
    logic [WB-1:0]   word_acc;
    logic            word_done;
    logic [1:0]      bif_after;
    logic [LB:0]     hdr_sum;
    logic            short_field;
    logic            hdr_end;
    logic            fin;
    logic [2:0]      fin_code;

    always_comb
    begin
        b             = item.data_byte;
        pl_dec        = payload_left_reg - LB'(1);
        dl_dec        = data_left_reg - LB'(1);
        hl_dec        = headers_left_reg - BB'(1);
        src_minus_hdr = source_len_reg - LB'(mfp_pkg::FIELD_BYTES);
        word_acc      = (bif_reg == 2'd0) ? WB'(b) : {acc_reg[WB-BB-1:0], b};
        word_done     = (bif_reg == 2'd3);
        bif_after     = word_done ? 2'd0 : bif_reg + 2'd1;
        hdr_sum       = {1'b0, name_size_reg} + {1'b0, word_acc[LB-1:0]};
        // Fewer bytes than a whole length or count field left in the payload.
        short_field   = (pl_dec < LB'(mfp_pkg::FIELD_BYTES));

        phase_next        = phase_reg;
        bif_next          = bif_reg;
        acc_next          = acc_reg;
        payload_left_next = payload_left_reg;
        source_len_next   = source_len_reg;
        headers_left_next = headers_left_reg;
        cur_hdr_next      = cur_hdr_reg;
        name_size_next    = name_size_reg;
        data_left_next    = data_left_reg;
        final_status_next = final_status_reg;
        result            = '0;
        hdr_end           = 1'b0;
        fin               = 1'b0;
        fin_code          = mfp_pkg::ST_BUSY;

        if (item.command == mfp_pkg::CMD_BEGIN)
        begin
            source_len_next   = item.buffer_len;
            bif_next          = 2'd0;
            acc_next          = '0;
            payload_left_next = '0;
            headers_left_next = '0;
            cur_hdr_next      = '0;
            name_size_next    = '0;
            data_left_next    = '0;
            final_status_next = mfp_pkg::ST_BUSY;
            if (item.buffer_len < LB'(mfp_pkg::FIELD_BYTES))
            begin
                fin      = 1'b1;
                fin_code = mfp_pkg::ST_INVALID;
            end
            else
            begin
                phase_next = PH_LEN;
            end
        end
        else if (phase_reg == PH_IDLE)
        begin
            result.data_byte_out = b;
            result.status        = final_status_reg;
        end
        else
        begin
            result.data_byte_out = b;
            result.byte_class    = phase_reg;
            if (phase_reg != PH_LEN)
            begin
                payload_left_next = pl_dec;
            end
            if (phase_reg == PH_NLEN || phase_reg == PH_NAME ||
                phase_reg == PH_VLEN || phase_reg == PH_VALUE)
            begin
                result.header_index = cur_hdr_reg;
            end

            case (phase_reg)
                PH_LEN:
                begin
                    acc_next           = word_acc;
                    bif_next           = bif_after;
                    result.field_value = word_acc;
                    if (word_done)
                    begin
                        result.field_complete = 1'b1;
                        if (word_acc > WB'(cfg.max_payload))
                        begin
                            fin      = 1'b1;
                            fin_code = mfp_pkg::ST_TOO_LARGE;
                        end
                        else if (word_acc > WB'(src_minus_hdr) || word_acc == '0)
                        begin
                            fin      = 1'b1;
                            fin_code = mfp_pkg::ST_INVALID;
                        end
                        else
                        begin
                            payload_left_next = word_acc[LB-1:0];
                            phase_next        = PH_TYPE;
                        end
                    end
                end
                PH_TYPE:
                begin
                    result.field_value    = WB'(b);
                    result.field_complete = 1'b1;
                    if (b > cfg.max_type || short_field)
                    begin
                        fin      = 1'b1;
                        fin_code = mfp_pkg::ST_INVALID;
                    end
                    else
                    begin
                        phase_next = PH_COUNT;
                        bif_next   = 2'd0;
                    end
                end
                PH_COUNT:
                begin
                    acc_next           = word_acc;
                    bif_next           = bif_after;
                    result.field_value = word_acc;
                    if (word_done)
                    begin
                        result.field_complete = 1'b1;
                        if (word_acc > WB'(cfg.header_limit) ||
                            word_acc > WB'(cfg.table_size))
                        begin
                            fin      = 1'b1;
                            fin_code = mfp_pkg::ST_TOO_MANY_HDRS;
                        end
                        else if (word_acc == '0)
                        begin
                            if (pl_dec == '0)
                            begin
                                fin      = 1'b1;
                                fin_code = mfp_pkg::ST_OK;
                            end
                            else
                            begin
                                phase_next = PH_BODY;
                            end
                        end
                        else
                        begin
                            headers_left_next = word_acc[BB-1:0];
                            cur_hdr_next      = '0;
                            if (short_field)
                            begin
                                fin      = 1'b1;
                                fin_code = mfp_pkg::ST_BAD_HEADER;
                            end
                            else
                            begin
                                phase_next = PH_NLEN;
                                bif_next   = 2'd0;
                            end
                        end
                    end
                end
                PH_NLEN:
                begin
                    acc_next           = word_acc;
                    bif_next           = bif_after;
                    result.field_value = word_acc;
                    if (word_done)
                    begin
                        result.field_complete = 1'b1;
                        if (word_acc > WB'(pl_dec))
                        begin
                            fin      = 1'b1;
                            fin_code = mfp_pkg::ST_BAD_HEADER;
                        end
                        else
                        begin
                            name_size_next = word_acc[LB-1:0];
                            if (word_acc != '0)
                            begin
                                data_left_next = word_acc[LB-1:0];
                                phase_next     = PH_NAME;
                            end
                            else if (short_field)
                            begin
                                fin      = 1'b1;
                                fin_code = mfp_pkg::ST_BAD_HEADER;
                            end
                            else
                            begin
                                phase_next = PH_VLEN;
                                bif_next   = 2'd0;
                            end
                        end
                    end
                end
                PH_NAME:
                begin
                    data_left_next = dl_dec;
                    if (dl_dec == '0)
                    begin
                        if (short_field)
                        begin
                            fin      = 1'b1;
                            fin_code = mfp_pkg::ST_BAD_HEADER;
                        end
                        else
                        begin
                            phase_next = PH_VLEN;
                            bif_next   = 2'd0;
                        end
                    end
                end
                PH_VLEN:
                begin
                    acc_next           = word_acc;
                    bif_next           = bif_after;
                    result.field_value = word_acc;
                    if (word_done)
                    begin
                        result.field_complete = 1'b1;
                        if (word_acc > WB'(pl_dec))
                        begin
                            fin      = 1'b1;
                            fin_code = mfp_pkg::ST_BAD_HEADER;
                        end
                        else if (hdr_sum > {1'b0, cfg.max_header_bytes})
                        begin
                            fin      = 1'b1;
                            fin_code = mfp_pkg::ST_HEADER_LARGE;
                        end
                        else if (word_acc != '0)
                        begin
                            data_left_next = word_acc[LB-1:0];
                            phase_next     = PH_VALUE;
                        end
                        else
                        begin
                            hdr_end = 1'b1;
                        end
                    end
                end
                PH_VALUE:
                begin
                    data_left_next = dl_dec;
                    if (dl_dec == '0)
                    begin
                        hdr_end = 1'b1;
                    end
                end
                PH_BODY:
                begin
                    if (pl_dec == '0)
                    begin
                        fin      = 1'b1;
                        fin_code = mfp_pkg::ST_OK;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase

            // Closing a header moves on to the next one or to the body, or ends the frame.
            if (hdr_end)
            begin
                cur_hdr_next      = cur_hdr_reg + BB'(1);
                headers_left_next = hl_dec;
                if (hl_dec != '0)
                begin
                    if (short_field)
                    begin
                        fin      = 1'b1;
                        fin_code = mfp_pkg::ST_BAD_HEADER;
                    end
                    else
                    begin
                        phase_next = PH_NLEN;
                        bif_next   = 2'd0;
                    end
                end
                else if (pl_dec == '0)
                begin
                    fin      = 1'b1;
                    fin_code = mfp_pkg::ST_OK;
                end
                else
                begin
                    phase_next = PH_BODY;
                end
            end
        end

        // Ending the frame, cleanly or with an error.
        if (fin)
        begin
            phase_next        = PH_IDLE;
            final_status_next = fin_code;
            result.status     = fin_code;
            result.frame_done = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            bif_reg          <= '0;
            acc_reg          <= '0;
            payload_left_reg <= '0;
            source_len_reg   <= '0;
            headers_left_reg <= '0;
            cur_hdr_reg      <= '0;
            name_size_reg    <= '0;
            data_left_reg    <= '0;
            final_status_reg <= mfp_pkg::ST_BUSY;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            bif_reg          <= bif_next;
            acc_reg          <= acc_next;
            payload_left_reg <= payload_left_next;
            source_len_reg   <= source_len_next;
            headers_left_reg <= headers_left_next;
            cur_hdr_reg      <= cur_hdr_next;
            name_size_reg    <= name_size_next;
            data_left_reg    <= data_left_next;
            final_status_reg <= final_status_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/message_frame_parser.sv @@
// Top level of the message frame parser: input register, parser and result register.
`default_nettype none

// The parser takes one command per transfer on the item channel: a begin
// command that opens a frame and samples the source buffer length, or one
// frame byte. Every transfer in yields exactly one transfer out on the result
// channel, in order, carrying the byte, its field class, its header index, the
// big-endian field value assembled so far, and a status that is nonzero on the
// byte that ends the frame, whether cleanly or by an error; bytes that arrive
// with no frame open are passed through as ignored and repeat the last status.
// The block sustains one transfer per clock cycle while the result side is not
// stalled. A transfer is captured in the input register, is decided by a single
// pass of compare and count logic against the frame state, and is then
// registered in the result register. A stalled result stops the pipeline;
// item_stall follows result_stall in the same cycle while the input register
// and the result register are occupied. The configuration registers may only
// be written while no transfer is in flight. There is no memory and no
// clearing sequence after reset: the block takes items from the first cycle.
module message_frame_parser (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               item_valid,
    output logic                                    item_stall,
    input  wire mfp_pkg::mfp_in_t                   item,
    output logic                                    result_valid,
    input  wire logic                               result_stall,
    output mfp_pkg::mfp_out_t                       result,
    input  wire logic                               cfg_we,
    input  wire logic [mfp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [mfp_pkg::LEN_BITS-1:0]       cfg_wdata
);

    mfp_pkg::mfp_cfg_t cfg;
    mfp_pkg::mfp_in_t  item_reg;
    logic              item_valid_reg, item_valid_next;
    mfp_pkg::mfp_out_t result_reg;
    mfp_pkg::mfp_out_t step_result;
    logic              result_valid_reg, result_valid_next;
    logic              advance;
    logic              step;
    logic              item_take;

    mfp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mfp_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item_reg),
        .cfg    (cfg),
        .result (step_result)
    );

    // The result register can take a new value when it is empty or is being
    // emptied by a transfer in this cycle.
    always_comb
    begin
        advance           = !result_valid_reg || !result_stall;
        step              = item_valid_reg && advance;
        item_stall        = item_valid_reg && !advance;
        item_take         = item_valid && !item_stall;
        item_valid_next   = item_take || (item_valid_reg && !step);
        result_valid_next = advance ? step : result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            item_reg <= item;
        end
        if (step)
        begin
            result_reg <= step_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A frame can only end with a real status code.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.frame_done |-> result.status != mfp_pkg::ST_BUSY)
        else $error("frame ended with busy status");

    // A byte inside an open frame that does not end it reports busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.byte_class != mfp_pkg::CLS_IGNORED && !result.frame_done
        |-> result.status == mfp_pkg::ST_BUSY)
        else $error("status reported without ending the frame");

    // Only length, type, count, name-length and value-length fields complete.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.field_complete
        |-> result.byte_class == mfp_pkg::CLS_LENGTH ||
            result.byte_class == mfp_pkg::CLS_TYPE ||
            result.byte_class == mfp_pkg::CLS_COUNT ||
            result.byte_class == mfp_pkg::CLS_NAME_LEN ||
            result.byte_class == mfp_pkg::CLS_VALUE_LEN)
        else $error("field completion on a data byte");

    // The pipeline holds the input only while the result side is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall && item_valid_reg)
        else $error("input stalled without a stalled result");

endmodule

`default_nettype wire
